// ===== rtl/kccd_pkg.sv =====
// ----------------------------------------------------------------------------
// kccd_pkg
// Shared widths, codes and control bundles of the kernel column cache directory
// ----------------------------------------------------------------------------
`default_nettype none

package kccd_pkg;

    // request and result field widths
    localparam int POINT_W     = 12;
    localparam int SLOT_OUT_W  = 10;
    localparam int COUNT_W     = 32;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int PIU_W       = 13;
    localparam int SIU_W       = 11;

    // width that holds any point or slot limit up to 65536
    localparam int LIMIT_W     = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_FULL_MATRIX_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POINTS_IN_USE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOTS_IN_USE     = 2'd2;

    localparam logic OP_ELEMENT = 1'b0;
    localparam logic OP_COLUMN  = 1'b1;

    // command bundle to the slot ring
    typedef struct packed {
        logic rd_en;   // read the entry under the ring pointer
        logic load;    // claim the slot under the pointer and advance
        logic clear;   // clearing sweep write
    } ring_cmd_t;

endpackage : kccd_pkg

`default_nettype wire

// ===== rtl/kccd_req_if.sv =====
// ----------------------------------------------------------------------------
// kccd_req_if
// Request channel: opcode and point indices with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface kccd_req_if;
    import kccd_pkg::*;

    logic               valid;
    logic               ready;
    logic               opcode;
    logic [POINT_W-1:0] first_point;
    logic [POINT_W-1:0] second_point;

    modport source (output valid, opcode, first_point, second_point, input ready);
    modport sink   (input valid, opcode, first_point, second_point, output ready);
endinterface : kccd_req_if

`default_nettype wire

// ===== rtl/kccd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// kccd_rsp_if
// Result channel: slot, row, load and eviction report with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface kccd_rsp_if;
    import kccd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  direct_access;
    logic [SLOT_OUT_W-1:0] slot;
    logic [POINT_W-1:0]    row_point;
    logic                  load_needed;
    logic [POINT_W-1:0]    loaded_point;
    logic                  evicted_valid;
    logic [POINT_W-1:0]    evicted_point;
    logic [COUNT_W-1:0]    load_total;

    modport source (
        output valid, direct_access, slot, row_point, load_needed, loaded_point,
               evicted_valid, evicted_point, load_total,
        input  ready
    );
    modport sink (
        input  valid, direct_access, slot, row_point, load_needed, loaded_point,
               evicted_valid, evicted_point, load_total,
        output ready
    );
endinterface : kccd_rsp_if

`default_nettype wire

// ===== rtl/kccd_point_map.sv =====
// ----------------------------------------------------------------------------
// kccd_point_map
// Point to slot map: synchronous memory, two read ports and one write port
// ----------------------------------------------------------------------------
`default_nettype none

module kccd_point_map #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 11
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr_a,
    input  wire logic [AW-1:0] rd_addr_b,
    output logic      [DW-1:0] rd_data_a,
    output logic      [DW-1:0] rd_data_b,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule : kccd_point_map

`default_nettype wire

// ===== rtl/kccd_slot_ring.sv =====
// ----------------------------------------------------------------------------
// kccd_slot_ring
// Slot owner memory and FIFO replacement pointer
// ----------------------------------------------------------------------------
`default_nettype none

module kccd_slot_ring #(
    parameter int MAX_SLOTS = 1024,
    parameter int SW        = 10,
    parameter int PW        = 12
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire kccd_pkg::ring_cmd_t          cmd,
    input  wire logic [SW-1:0]                clr_idx,
    input  wire logic [PW-1:0]                load_point,
    input  wire logic [kccd_pkg::SIU_W-1:0]   slots_in_use,
    output logic      [SW-1:0]                ptr,
    output logic                              owner_valid,
    output logic      [PW-1:0]                owner_point
);
    import kccd_pkg::*;

    localparam logic [LIMIT_W-1:0] MaxSlotsW = LIMIT_W'(MAX_SLOTS);

    logic [PW:0]          mem [MAX_SLOTS];
    logic [SW-1:0]        ptr_reg;
    logic [SW-1:0]        ptr_next;
    logic [LIMIT_W-1:0]   slot_lim;
    logic [LIMIT_W-1:0]   ptr_inc;
    logic [PW:0]          rd_reg;
    logic                 wr_en;
    logic [SW-1:0]        wr_addr;
    logic [PW:0]          wr_data;

    // zero acts as one, above the ring size acts as the ring size
    always_comb
    begin
        if (slots_in_use == '0)
        begin
            slot_lim = LIMIT_W'(1);
        end
        else if (LIMIT_W'(slots_in_use) > MaxSlotsW)
        begin
            slot_lim = MaxSlotsW;
        end
        else
        begin
            slot_lim = LIMIT_W'(slots_in_use);
        end
        ptr_inc  = LIMIT_W'(ptr_reg) + LIMIT_W'(1);
        ptr_next = (ptr_inc >= slot_lim) ? '0 : SW'(ptr_inc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.load)
        begin
            ptr_reg <= ptr_next;
        end
    end

    always_comb
    begin
        wr_en   = cmd.load || cmd.clear;
        wr_addr = cmd.clear ? clr_idx : ptr_reg;
        wr_data = cmd.clear ? '0 : {1'b1, load_point};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_reg <= mem[ptr_reg];
        end
    end

    assign ptr         = ptr_reg;
    assign owner_valid = rd_reg[PW];
    assign owner_point = rd_reg[PW-1:0];

endmodule : kccd_slot_ring

`default_nettype wire

// ===== rtl/kernel_column_cache_directory_unit.sv =====
// ----------------------------------------------------------------------------
// kernel_column_cache_directory_unit
// Directory of a FIFO-replaced column cache for a symmetric kernel matrix
// ----------------------------------------------------------------------------
// usage
//   req carries an element request (point pair) or a column request (one
//   point); rsp returns one result per request: slot and row to read, or on a
//   miss the point whose column must be loaded and the point evicted from it
//   cfg_write_en/cfg_index/cfg_data write the mode and limits; write them only
//   while no request is in flight
//   a request is taken in one cycle and its lookup reads the point map and the
//   slot ring in the next; a miss that evicts an owner also passes the
//   eviction state, as the single write port of the point map takes the new
//   mapping and the cleared old mapping one after the other
//   the result sits in an output register; a stalled receiver holds it there
//   while the next request is taken and looked up, and the lookup waits for
//   the register to drain before committing
//   after reset both memories are swept clear, one entry a cycle, over
//   max(MAX_POINTS, MAX_SLOTS) addresses, during which req.ready stays low;
//   configuration writes are taken throughout
// ----------------------------------------------------------------------------
`default_nettype none

module kernel_column_cache_directory_unit #(
    parameter int MAX_POINTS = 4096,
    parameter int MAX_SLOTS  = 1024
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write_en,
    input  wire logic [kccd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [kccd_pkg::CFG_DATA_W-1:0]  cfg_data,
    kccd_req_if.sink                              req,
    kccd_rsp_if.source                            rsp
);
    import kccd_pkg::*;

    localparam int PW         = $clog2(MAX_POINTS);
    localparam int SW         = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int ClearDepth = (MAX_POINTS > MAX_SLOTS) ? MAX_POINTS : MAX_SLOTS;
    localparam int CW         = $clog2(ClearDepth);
    localparam logic [LIMIT_W-1:0] MaxPointsW = LIMIT_W'(MAX_POINTS);
    localparam logic [LIMIT_W-1:0] MaxSlotsW  = LIMIT_W'(MAX_SLOTS);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_LOOK  = 4'b0100,
        ST_EVICT = 4'b1000
    } state_t;

    typedef struct packed {
        logic                  direct_access;
        logic [SLOT_OUT_W-1:0] slot;
        logic [POINT_W-1:0]    row_point;
        logic                  load_needed;
        logic [POINT_W-1:0]    loaded_point;
        logic                  evicted_valid;
        logic [POINT_W-1:0]    evicted_point;
        logic [COUNT_W-1:0]    load_total;
    } rsp_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        clr_cnt_reg;

    // configuration
    logic                 full_matrix_mode_reg;
    logic [PIU_W-1:0]     points_in_use_reg;
    logic [SIU_W-1:0]     slots_in_use_reg;

    // request held for the lookup
    logic                 op_reg;
    logic [POINT_W-1:0]   first_reg;
    logic [POINT_W-1:0]   second_reg;
    logic                 in_range_reg;

    logic [COUNT_W-1:0]   load_cnt_reg, load_cnt_next;
    logic                 out_valid_reg;
    rsp_t                 out_reg, res;

    logic [LIMIT_W-1:0]   point_lim;
    logic                 req_take;
    logic                 look_go;
    logic                 do_load;
    logic [PW-1:0]        load_point;
    logic                 clr_map, clr_ring;

    // point map ports
    logic [SW:0]          map_a, map_b;
    logic                 map_wr_en;
    logic [PW-1:0]        map_wr_addr;
    logic [SW:0]          map_wr_data;

    // slot ring ports
    ring_cmd_t            ring_cmd;
    logic [SW-1:0]        ring_ptr;
    logic                 owner_valid;
    logic [PW-1:0]        owner_point;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_matrix_mode_reg <= 1'b0;
            points_in_use_reg    <= PIU_W'(4096);
            slots_in_use_reg     <= SIU_W'(1024);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_FULL_MATRIX_MODE: full_matrix_mode_reg <= cfg_data[0];
                CFG_POINTS_IN_USE:    points_in_use_reg    <= cfg_data[PIU_W-1:0];
                CFG_SLOTS_IN_USE:     slots_in_use_reg     <= cfg_data[SIU_W-1:0];
                default:              ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // request intake and range check
    // ------------------------------------------------------------------
    assign point_lim = (LIMIT_W'(points_in_use_reg) > MaxPointsW) ?
                       MaxPointsW : LIMIT_W'(points_in_use_reg);

    assign req.ready = (state_reg == ST_IDLE);
    assign req_take  = req.valid && req.ready;

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            op_reg       <= req.opcode;
            first_reg    <= req.first_point;
            second_reg   <= req.second_point;
            // every point the request uses must lie below the point limit
            in_range_reg <= (LIMIT_W'(req.first_point) < point_lim) &&
                            ((req.opcode == OP_COLUMN) ||
                             (LIMIT_W'(req.second_point) < point_lim));
        end
    end

    // ------------------------------------------------------------------
    // lookup: decide hit, bypass or load from the registered map reads
    // ------------------------------------------------------------------
    assign look_go = (state_reg == ST_LOOK) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        res        = '0;
        do_load    = 1'b0;
        load_point = PW'(second_reg);
        if (in_range_reg)
        begin
            if (full_matrix_mode_reg)
            begin
                // whole matrix stored, point straight at it
                res.direct_access = 1'b1;
                res.row_point     = (op_reg == OP_ELEMENT) ? second_reg : '0;
            end
            else if (op_reg == OP_ELEMENT)
            begin
                if (map_a[SW])
                begin
                    res.slot      = SLOT_OUT_W'(map_a[SW-1:0]);
                    res.row_point = second_reg;
                end
                else if (map_b[SW])
                begin
                    // symmetric matrix: read the other column
                    res.slot      = SLOT_OUT_W'(map_b[SW-1:0]);
                    res.row_point = first_reg;
                end
                else
                begin
                    do_load       = 1'b1;
                    load_point    = PW'(second_reg);
                    res.row_point = first_reg;
                end
            end
            else
            begin
                if (map_a[SW])
                begin
                    res.slot = SLOT_OUT_W'(map_a[SW-1:0]);
                end
                else
                begin
                    do_load    = 1'b1;
                    load_point = PW'(first_reg);
                end
            end
        end
        if (do_load)
        begin
            res.slot          = SLOT_OUT_W'(ring_ptr);
            res.load_needed   = 1'b1;
            res.loaded_point  = (op_reg == OP_ELEMENT) ? second_reg : first_reg;
            res.evicted_valid = owner_valid;
            res.evicted_point = owner_valid ? POINT_W'(owner_point) : '0;
        end
        load_cnt_next = (do_load && (load_cnt_reg != '1)) ?
                        load_cnt_reg + COUNT_W'(1) : load_cnt_reg;
        res.load_total = load_cnt_next;
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == CW'(ClearDepth - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_take)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (look_go)
                begin
                    state_next = (do_load && owner_valid) ? ST_EVICT : ST_IDLE;
                end
            end
            ST_EVICT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            load_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
            end
            if (look_go)
            begin
                load_cnt_reg  <= load_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (look_go)
        begin
            out_reg <= res;
        end
    end

    // ------------------------------------------------------------------
    // memory writes
    // every valid ring entry's owner maps back to that slot, and a loaded
    // point is never mapped, so the evicted owner's entry is cleared outright
    // ------------------------------------------------------------------
    assign clr_map  = (state_reg == ST_CLEAR) && (LIMIT_W'(clr_cnt_reg) < MaxPointsW);
    assign clr_ring = (state_reg == ST_CLEAR) && (LIMIT_W'(clr_cnt_reg) < MaxSlotsW);

    always_comb
    begin
        map_wr_en   = 1'b0;
        map_wr_addr = clr_cnt_reg[PW-1:0];
        map_wr_data = '0;
        if (clr_map)
        begin
            map_wr_en = 1'b1;
        end
        else if (look_go && do_load)
        begin
            map_wr_en   = 1'b1;
            map_wr_addr = load_point;
            map_wr_data = {1'b1, ring_ptr};
        end
        else if (state_reg == ST_EVICT)
        begin
            map_wr_en   = 1'b1;
            map_wr_addr = owner_point;
        end
    end

    always_comb
    begin
        ring_cmd.rd_en = req_take;
        ring_cmd.load  = look_go && do_load;
        ring_cmd.clear = clr_ring;
    end

    kccd_point_map #(
        .DEPTH (MAX_POINTS),
        .AW    (PW),
        .DW    (SW + 1)
    ) u_point_map (
        .clk       (clk),
        .rd_en     (req_take),
        .rd_addr_a (PW'(req.first_point)),
        .rd_addr_b (PW'(req.second_point)),
        .rd_data_a (map_a),
        .rd_data_b (map_b),
        .wr_en     (map_wr_en),
        .wr_addr   (map_wr_addr),
        .wr_data   (map_wr_data)
    );

    kccd_slot_ring #(
        .MAX_SLOTS (MAX_SLOTS),
        .SW        (SW),
        .PW        (PW)
    ) u_slot_ring (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (ring_cmd),
        .clr_idx      (clr_cnt_reg[SW-1:0]),
        .load_point   (load_point),
        .slots_in_use (slots_in_use_reg),
        .ptr          (ring_ptr),
        .owner_valid  (owner_valid),
        .owner_point  (owner_point)
    );

    // ------------------------------------------------------------------
    // result port
    // ------------------------------------------------------------------
    assign rsp.valid         = out_valid_reg;
    assign rsp.direct_access = out_reg.direct_access;
    assign rsp.slot          = out_reg.slot;
    assign rsp.row_point     = out_reg.row_point;
    assign rsp.load_needed   = out_reg.load_needed;
    assign rsp.loaded_point  = out_reg.loaded_point;
    assign rsp.evicted_valid = out_reg.evicted_valid;
    assign rsp.evicted_point = out_reg.evicted_point;
    assign rsp.load_total    = out_reg.load_total;

endmodule : kernel_column_cache_directory_unit

`default_nettype wire

// ===== rtl/kccd_checker.sv =====
// ----------------------------------------------------------------------------
// kccd_checker
// Port-level checks of the kernel column cache directory
// ----------------------------------------------------------------------------
`default_nettype none

module kccd_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            req_valid,
    input wire logic                            req_ready,
    input wire logic                            rsp_valid,
    input wire logic                            rsp_ready,
    input wire logic                            direct_access,
    input wire logic [kccd_pkg::SLOT_OUT_W-1:0] slot,
    input wire logic                            load_needed,
    input wire logic                            evicted_valid,
    input wire logic [kccd_pkg::COUNT_W-1:0]    load_total
);

    // a stalled result holds its counter value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(load_total))
        else $error("stalled result changed");

    // requests are never taken back to back
    a_req_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken in back-to-back cycles");

    // bypass never loads and names slot zero
    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && direct_access |-> !load_needed && (slot == '0))
        else $error("bypass result reports a load");

    // eviction only comes with a load, and a load is counted
    a_evict_load: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && evicted_valid |-> load_needed && (load_total != '0))
        else $error("eviction without a counted load");

endmodule : kccd_checker

bind kernel_column_cache_directory_unit kccd_checker u_kccd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .direct_access (rsp.direct_access),
    .slot          (rsp.slot),
    .load_needed   (rsp.load_needed),
    .evicted_valid (rsp.evicted_valid),
    .load_total    (rsp.load_total)
);

`default_nettype wire

// ===== verif/kernel_column_cache_directory_unit_tb.sv =====
// ----------------------------------------------------------------------------
// kernel_column_cache_directory_unit_tb
// Self-checking bench for the FIFO column cache directory: a short table of
// hand-picked requests and register writes, then random phases of requests
// over hot point pools and changing limits, each result checked field by
// field against a hand-written result or a cycle-free model of the point map and slot ring
// ----------------------------------------------------------------------------

module kernel_column_cache_directory_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kccd_pkg::*;

    localparam int MAX_POINTS    = 4096;
    localparam int MAX_SLOTS     = 1024;
    localparam int RANDOM_ITEMS  = 1650;
    // settle time after the last result covers the eviction state of a miss that evicts
    localparam int SETTLE_CYCLES = 8;
    // budget for the clear sweep plus ~1700 requests, each with its sender gap,
    // miss and long receiver stall, several times over
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct packed {
        logic               opcode;
        logic [POINT_W-1:0] first_point;
        logic [POINT_W-1:0] second_point;
    } lookup_req_t;

    typedef struct packed {
        logic                  direct_access;
        logic [SLOT_OUT_W-1:0] slot;
        logic [POINT_W-1:0]    row_point;
        logic                  load_needed;
        logic [POINT_W-1:0]    loaded_point;
        logic                  evicted_valid;
        logic [POINT_W-1:0]    evicted_point;
        logic [COUNT_W-1:0]    load_total;
    } lookup_res_t;

    // one line of the directed table: a register write, a request checked
    // against the model, or a request with its result written out by hand
    typedef enum logic [1:0] {ROW_CFG, ROW_REQ, ROW_CHECK} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        lookup_req_t            rq;
        lookup_res_t            want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    kccd_req_if req();
    kccd_rsp_if rsp();

    kernel_column_cache_directory_unit #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_SLOTS  (MAX_SLOTS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req          (req),
        .rsp          (rsp)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // directory model: point map, slot ring, ring pointer, load count
    // ------------------------------------------------------------------
    bit                    point_cached [MAX_POINTS];
    logic [SLOT_OUT_W-1:0] point_slot   [MAX_POINTS];
    bit                    slot_taken   [MAX_SLOTS];
    logic [POINT_W-1:0]    slot_owner   [MAX_SLOTS];
    logic [SLOT_OUT_W-1:0] replace_ptr;
    logic [COUNT_W-1:0]    column_loads;

    // register copies as last written
    logic           full_mode;
    logic [12:0]    points_reg;
    logic [10:0]    slots_reg;

    lookup_res_t expected_lookups [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    // hot pool of the current random phase
    logic [POINT_W-1:0] hot_points [64];
    int unsigned        hot_count;
    int unsigned        phase_lim;

    function automatic int unsigned point_limit();
        return (points_reg > MAX_POINTS) ? MAX_POINTS : int'(points_reg);
    endfunction

    // a request only counts when every point it uses is below the limit
    function automatic bit request_in_range(lookup_req_t rq);
        int unsigned lim;
        lim = point_limit();
        return (rq.first_point < lim) && (rq.opcode == OP_COLUMN || rq.second_point < lim);
    endfunction

    // claim the slot under the ring pointer for point p, evicting its owner
    function automatic logic [SLOT_OUT_W-1:0] fill_column(input logic [POINT_W-1:0] p,
                                                          inout lookup_res_t r);
        logic [SLOT_OUT_W-1:0] s;
        logic [POINT_W-1:0]    owner;
        int unsigned           ring_len;
        int unsigned           nxt;
        s = replace_ptr;
        if (column_loads != '1)
            column_loads = column_loads + 1'b1;
        if (slot_taken[s])
        begin
            owner = slot_owner[s];
            r.evicted_valid = 1'b1;
            r.evicted_point = owner;
            // the owner may already have moved to another slot
            if (point_cached[owner] && point_slot[owner] == s)
                point_cached[owner] = 1'b0;
        end
        point_cached[p] = 1'b1;
        point_slot[p]   = s;
        slot_taken[s]   = 1'b1;
        slot_owner[s]   = p;
        // slot count of 0 acts as 1, above the ring size acts as the ring size
        ring_len = (slots_reg == 0) ? 1 : (slots_reg > MAX_SLOTS) ? MAX_SLOTS : int'(slots_reg);
        nxt = int'(s) + 1;
        // a pointer left beyond a shrunk ring is used once, then wraps
        replace_ptr = (nxt >= ring_len) ? '0 : SLOT_OUT_W'(nxt);
        r.load_needed  = 1'b1;
        r.loaded_point = p;
        return s;
    endfunction

    function automatic lookup_res_t predict_lookup(lookup_req_t rq);
        lookup_res_t           r;
        logic [SLOT_OUT_W-1:0] s;
        logic [POINT_W-1:0]    rowp;
        r    = '0;
        s    = '0;
        rowp = '0;
        if (request_in_range(rq))
        begin
            if (full_mode)
            begin
                // bypass: read the stored matrix, no state change
                r.direct_access = 1'b1;
                rowp = (rq.opcode == OP_ELEMENT) ? rq.second_point : '0;
            end
            else if (rq.opcode == OP_ELEMENT)
            begin
                // symmetric matrix: either point's column holds the element
                if (point_cached[rq.first_point])
                begin
                    s    = point_slot[rq.first_point];
                    rowp = rq.second_point;
                end
                else if (point_cached[rq.second_point])
                begin
                    s    = point_slot[rq.second_point];
                    rowp = rq.first_point;
                end
                else
                begin
                    s    = fill_column(rq.second_point, r);
                    rowp = rq.first_point;
                end
            end
            else
            begin
                if (point_cached[rq.first_point])
                    s = point_slot[rq.first_point];
                else
                    s = fill_column(rq.first_point, r);
            end
            r.slot      = s;
            r.row_point = rowp;
        end
        r.load_total = column_loads;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // directed table rows
    // ------------------------------------------------------------------
    function automatic plan_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        plan_row_t row;
        row           = '0;
        row.kind      = ROW_CFG;
        row.reg_index = idx;
        row.reg_value = v;
        return row;
    endfunction

    function automatic plan_row_t req_row(logic op, logic [POINT_W-1:0] a, logic [POINT_W-1:0] b);
        plan_row_t row;
        row                 = '0;
        row.kind            = ROW_REQ;
        row.rq.opcode       = op;
        row.rq.first_point  = a;
        row.rq.second_point = b;
        return row;
    endfunction

    function automatic plan_row_t chk_row(logic op, logic [POINT_W-1:0] a, logic [POINT_W-1:0] b,
                                          logic da, logic [SLOT_OUT_W-1:0] s,
                                          logic [POINT_W-1:0] rp, logic ld,
                                          logic [POINT_W-1:0] lp, logic ev,
                                          logic [POINT_W-1:0] ep, logic [COUNT_W-1:0] tot);
        plan_row_t row;
        row      = req_row(op, a, b);
        row.kind = ROW_CHECK;
        row.want = '{da, s, rp, ld, lp, ev, ep, tot};
        return row;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // results are taken at the rising edge, against the oldest pending request
    always @(posedge clk)
    begin
        lookup_res_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_lookups.size() == 0)
            begin
                report_mismatch("result with no request pending");
            end
            else
            begin
                want = expected_lookups.pop_front();
                check_field("direct_access", 32'(rsp.direct_access), 32'(want.direct_access));
                check_field("slot",          32'(rsp.slot),          32'(want.slot));
                check_field("row_point",     32'(rsp.row_point),     32'(want.row_point));
                check_field("load_needed",   32'(rsp.load_needed),   32'(want.load_needed));
                check_field("loaded_point",  32'(rsp.loaded_point),  32'(want.loaded_point));
                check_field("evicted_valid", 32'(rsp.evicted_valid), 32'(want.evicted_valid));
                check_field("evicted_point", 32'(rsp.evicted_point), 32'(want.evicted_point));
                check_field("load_total",    rsp.load_total,         want.load_total);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // receiver: stretches of always ready, coin flips, a fixed every-fourth
    // stall and mostly stalled
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned mode;
        int unsigned left;
        rsp.ready = 1'b0;
        mode = 0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(8, 64);
            end
            left--;
            case (mode)
                0:       rsp.ready <= 1'b1;
                1:       rsp.ready <= ($urandom_range(0, 1) == 1);
                2:       rsp.ready <= (left[1:0] != 2'd0);
                default: rsp.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sender side, every task entered and left at a falling edge
    // ------------------------------------------------------------------

    // present one request after an optional gap, hold it until taken, then
    // record what the directory should answer
    task automatic send_lookup(input lookup_req_t rq, input bit typed, input lookup_res_t want,
                               input int unsigned gap);
        lookup_res_t predicted;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid        <= 1'b1;
        req.opcode       <= rq.opcode;
        req.first_point  <= rq.first_point;
        req.second_point <= rq.second_point;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        // hand-written rows still run the model so its state stays in step
        predicted = predict_lookup(rq);
        expected_lookups.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // stop sending and let every pending request come back, plus the tail
    // of a miss that evicts
    task automatic drain_lookups();
        req.valid <= 1'b0;
        while (expected_lookups.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // registers change only while nothing is in flight
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= v;
        case (idx)
            CFG_FULL_MATRIX_MODE: full_mode  = v[0];
            CFG_POINTS_IN_USE:    points_reg = v[12:0];
            CFG_SLOTS_IN_USE:     slots_reg  = v[10:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [POINT_W-1:0] pick_point();
        int unsigned dice;
        dice = $urandom_range(0, 99);
        // any index, so out-of-range points and every bit show up
        if (dice < 8 || phase_lim == 0)
            return POINT_W'($urandom_range(0, MAX_POINTS - 1));
        // hot pool: hits, refills and evictions
        if (dice < 68)
            return hot_points[$urandom_range(0, hot_count - 1)];
        return POINT_W'($urandom_range(0, phase_lim - 1));
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        plan_row_t   plan [$];
        lookup_req_t rq;
        int unsigned counted;
        int unsigned phase_len;
        int unsigned burst_left;
        int unsigned gap;
        bit          steady;
        logic [12:0] pts_val;
        logic [10:0] slots_val;

        rst_n            = 1'b0;
        cfg_write_en     = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        req.valid        = 1'b0;
        req.opcode       = OP_ELEMENT;
        req.first_point  = '0;
        req.second_point = '0;

        // model starts from the reset state
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            point_cached[i] = 1'b0;
            point_slot[i]   = '0;
        end
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            slot_taken[i] = 1'b0;
            slot_owner[i] = '0;
        end
        replace_ptr  = '0;
        column_loads = '0;
        full_mode    = 1'b0;
        points_reg   = 13'd4096;
        slots_reg    = 11'd1024;

        // directed table
        // args: op, first, second, direct, slot, row, load, loaded, evict, evicted, total
        // first column after reset lands in slot 0
        plan.push_back(chk_row(OP_COLUMN,  0,    0,    0, 0, 0,    1, 0,    0, 0,   1));
        // element hit on the first point
        plan.push_back(chk_row(OP_ELEMENT, 0,    4095, 0, 0, 4095, 0, 0,    0, 0,   1));
        // element hit on the second point, row swaps to the first
        plan.push_back(chk_row(OP_ELEMENT, 4095, 0,    0, 0, 4095, 0, 0,    0, 0,   1));
        // element miss loads the second point
        plan.push_back(chk_row(OP_ELEMENT, 7,    9,    0, 1, 7,    1, 9,    0, 0,   2));
        plan.push_back(chk_row(OP_COLUMN,  4095, 0,    0, 2, 0,    1, 4095, 0, 0,   3));
        plan.push_back(chk_row(OP_ELEMENT, 9,    7,    0, 1, 7,    0, 0,    0, 0,   3));
        // shrink the ring below the pointer: slot 3 once, then wrap
        plan.push_back(cfg_row(CFG_SLOTS_IN_USE, 2));
        plan.push_back(chk_row(OP_COLUMN,  100,  0,    0, 3, 0,    1, 100,  0, 0,   4));
        plan.push_back(chk_row(OP_COLUMN,  200,  0,    0, 0, 0,    1, 200,  1, 0,   5));
        plan.push_back(chk_row(OP_COLUMN,  0,    0,    0, 1, 0,    1, 0,    1, 9,   6));
        // no valid points at all: everything ignored
        plan.push_back(cfg_row(CFG_POINTS_IN_USE, 0));
        plan.push_back(chk_row(OP_ELEMENT, 0,    0,    0, 0, 0,    0, 0,    0, 0,   6));
        // limit above the map size clamps
        plan.push_back(cfg_row(CFG_POINTS_IN_USE, 8191));
        plan.push_back(chk_row(OP_ELEMENT, 4095, 4095, 0, 2, 4095, 0, 0,    0, 0,   6));
        plan.push_back(cfg_row(CFG_POINTS_IN_USE, 50));
        // second point at the limit
        plan.push_back(chk_row(OP_ELEMENT, 10,   50,   0, 0, 0,    0, 0,    0, 0,   6));
        // column request ignores an out-of-range second point
        plan.push_back(chk_row(OP_COLUMN,  49,   4095, 0, 0, 0,    1, 49,   1, 200, 7));
        // first point at the limit
        plan.push_back(chk_row(OP_ELEMENT, 50,   49,   0, 0, 0,    0, 0,    0, 0,   7));
        // full-matrix bypass
        plan.push_back(cfg_row(CFG_FULL_MATRIX_MODE, 1));
        plan.push_back(chk_row(OP_ELEMENT, 49,   48,   1, 0, 48,   0, 0,    0, 0,   7));
        plan.push_back(chk_row(OP_COLUMN,  3,    0,    1, 0, 0,    0, 0,    0, 0,   7));
        plan.push_back(cfg_row(CFG_FULL_MATRIX_MODE, 0));
        // slot count of zero acts as a one-slot ring
        plan.push_back(cfg_row(CFG_SLOTS_IN_USE, 0));
        plan.push_back(chk_row(OP_COLUMN,  1,    0,    0, 1, 0,    1, 1,    1, 0,   8));
        plan.push_back(chk_row(OP_COLUMN,  2,    0,    0, 0, 0,    1, 2,    1, 49,  9));
        plan.push_back(chk_row(OP_ELEMENT, 1,    2,    0, 1, 2,    0, 0,    0, 0,   9));
        // slot count above the ring size clamps
        plan.push_back(cfg_row(CFG_SLOTS_IN_USE, 2047));
        plan.push_back(cfg_row(CFG_POINTS_IN_USE, 4096));
        plan.push_back(req_row(OP_COLUMN,  4094, 0));
        plan.push_back(req_row(OP_ELEMENT, 5,    5));
        plan.push_back(req_row(OP_ELEMENT, 4095, 0));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // the first request waits out the clearing sweep on ready
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                drain_lookups();
                write_reg(plan[i].reg_index, plan[i].reg_value);
            end
            else
            begin
                send_lookup(plan[i].rq, plan[i].kind == ROW_CHECK, plan[i].want,
                            $urandom_range(0, 2));
            end
        end

        // random phases, each under its own register setting
        counted    = 0;
        burst_left = 0;
        while (counted < RANDOM_ITEMS)
        begin
            drain_lookups();
            case ($urandom_range(0, 15))
                0:       pts_val = 13'd0;
                1:       pts_val = 13'd1;
                2:       pts_val = 13'd2;
                3:       pts_val = 13'd8191;
                4:       pts_val = 13'($urandom_range(0, 8191));
                5, 6, 7, 8: pts_val = 13'd4096;
                default: pts_val = 13'($urandom_range(3, 300));
            endcase
            case ($urandom_range(0, 15))
                0:       slots_val = 11'd0;
                1:       slots_val = 11'd1;
                2:       slots_val = 11'd2;
                3:       slots_val = 11'd2047;
                4:       slots_val = 11'd1024;
                5:       slots_val = 11'd1023;
                6:       slots_val = 11'($urandom_range(0, 2047));
                default: slots_val = 11'($urandom_range(1, 40));
            endcase
            write_reg(CFG_FULL_MATRIX_MODE, CFG_DATA_W'($urandom_range(0, 7) == 0));
            write_reg(CFG_POINTS_IN_USE, pts_val);
            write_reg(CFG_SLOTS_IN_USE, CFG_DATA_W'(slots_val));

            // hot pool inside the current limit
            phase_lim = point_limit();
            hot_count = $urandom_range(1, 48);
            for (int i = 0; i < 64; i++)
                hot_points[i] = (phase_lim == 0) ? '0 : POINT_W'($urandom_range(0, phase_lim - 1));

            phase_len = $urandom_range(60, 200);
            steady    = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < phase_len && counted < RANDOM_ITEMS; i++)
            begin
                // now and then hold off until every result is back
                if ($urandom_range(0, 49) == 0)
                    drain_lookups();
                rq.opcode       = ($urandom_range(0, 1) == 1) ? OP_COLUMN : OP_ELEMENT;
                rq.first_point  = pick_point();
                rq.second_point = pick_point();
                gap = 0;
                if (!steady)
                begin
                    if (burst_left == 0)
                    begin
                        gap        = $urandom_range(1, 8);
                        burst_left = $urandom_range(1, 24);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                counted++;
                send_lookup(rq, 1'b0, '0, gap);
            end
        end

        drain_lookups();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule : kernel_column_cache_directory_unit_tb
